// ===== rtl/image_rotate_nearest_defines.svh =====
// Assertion macros used by the image rotation RTL.
`ifndef IMAGE_ROTATE_NEAREST_DEFINES_SVH
`define IMAGE_ROTATE_NEAREST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IRN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IRN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/irn_pkg.sv =====
// Constants and types for the nearest-neighbor image rotator.
package irn_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_PIXEL_BITS = 32;

  localparam int FRAC_BITS     = 14;
  localparam int COORD_BITS    = 8;
  localparam int DIM_BITS      = 9;
  localparam int TRIG_BITS     = 16;
  localparam int PORT_PIX_BITS = 32;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COS    = 2'd2,
    REG_SIN    = 2'd3
  } reg_index_t;

endpackage

// ===== rtl/image_rotate_nearest.sv =====
// Nearest-neighbor image rotation about the center, frame store plus sequencer.
`include "image_rotate_nearest_defines.svh"

// Rotates an image about its center by inverse mapping. A load transfer
// (func=0) writes pixel_in into the frame store at row*MAX_WIDTH+col modulo
// DEPTH; a query transfer (func=1) maps destination (col,row) back through the
// rotation set by cos_q14/sin_q14 (signed Q1.14, truncation toward zero) and
// returns the source pixel with inside_res=1, or zero when the point falls off
// the image. Every input transfer yields exactly one output transfer. Items
// are handled one at a time by a sequencer around a single-port frame memory
// with a registered read. An inside query steps through multiply, sum, bounds
// check, linear address, address reduction, memory access and result
// hand-off; a query that maps outside stops after the bounds check, a query
// off the destination image goes straight to hand-off, and a load skips the
// mapping steps. Hand-off waits while the output register is held by
// out_ready low. A finished result sits in the output register while the next
// input is taken. The frame store has no reset; reading a pixel that was never
// loaded returns whatever it holds. Config writes are taken every cycle out of
// reset and belong in idle periods only.
module image_rotate_nearest
  import irn_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // config write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [TRIG_BITS-1:0]     cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     func,
  input  logic [COORD_BITS-1:0]    col,
  input  logic [COORD_BITS-1:0]    row,
  input  logic [PORT_PIX_BITS-1:0] pixel_in,
  // output channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PORT_PIX_BITS-1:0] pixel_out,
  output logic                     inside_res
);

  // Frame geometry. A load address may exceed the frame depth for small
  // frames, so the linear address is reduced modulo DEPTH by a reciprocal
  // multiply and a single corrective subtract.
  localparam longint unsigned DEPTH =
    longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
  localparam int AW = $clog2(DEPTH);
  localparam longint unsigned COORD_MAX = (64'd1 << COORD_BITS) - 64'd1;
  localparam longint unsigned LOAD_LIN_MAX =
    COORD_MAX * longint'(MAX_WIDTH) + COORD_MAX;
  localparam longint unsigned LIN_MAX =
    (LOAD_LIN_MAX > DEPTH - 64'd1) ? LOAD_LIN_MAX : DEPTH - 64'd1;
  localparam int LW = $clog2(LIN_MAX + 64'd1);
  localparam longint unsigned RECIP = (64'd1 << LW) / DEPTH;
  localparam int RW = $clog2(RECIP + 64'd1);

  // Mapping arithmetic widths: dx/dy span +-255, products 16x10 bits.
  localparam int DW  = DIM_BITS + 1;
  localparam int PW  = TRIG_BITS + DW;
  localparam int SW  = PW + 1;
  localparam int TQW = SW - FRAC_BITS;
  localparam int CW  = TQW + 2;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_SUM  = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_LIN  = 9'b000010000,
    S_RCP  = 9'b000100000,
    S_MOD  = 9'b001000000,
    S_MEM  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic        [DIM_BITS-1:0]  cfg_width;
  logic        [DIM_BITS-1:0]  cfg_height;
  logic signed [TRIG_BITS-1:0] cos_r;
  logic signed [TRIG_BITS-1:0] sin_r;

  // Item registers.
  logic                    func_r;
  logic [COORD_BITS-1:0]   col_r;
  logic [COORD_BITS-1:0]   row_r;
  logic [PIXEL_BITS-1:0]   pix_r;
  logic [DIM_BITS-1:0]     addr_row;
  logic [DIM_BITS-1:0]     addr_col;
  logic                    res_inside;

  logic signed [PW-1:0]    p_cos_dx;
  logic signed [PW-1:0]    p_sin_dy;
  logic signed [PW-1:0]    p_sin_dx;
  logic signed [PW-1:0]    p_cos_dy;
  logic signed [CW-1:0]    sx;
  logic signed [CW-1:0]    sy;

  logic [LW-1:0]           lin_r;
  logic [RW-1:0]           q_r;
  logic [AW-1:0]           addr_r;

  // Frame memory.
  logic [PIXEL_BITS-1:0]   frame [DEPTH];
  logic [PIXEL_BITS-1:0]   rd_data;
  logic                    mem_we;
  logic                    mem_re;

  // Effective (saturated) dimensions and center.
  logic [DIM_BITS-1:0]     w_eff;
  logic [DIM_BITS-1:0]     h_eff;
  logic [DIM_BITS-2:0]     cx;
  logic [DIM_BITS-2:0]     cy;
  logic                    off_dest;

  logic signed [DW-1:0]    dx;
  logic signed [DW-1:0]    dy;
  logic signed [SW-1:0]    sum_x;
  logic signed [SW-1:0]    sum_y;
  logic signed [CW-1:0]    tx;
  logic signed [CW-1:0]    ty;
  logic                    map_inside;

  logic [LW-1:0]           lin;
  logic [LW+RW-1:0]        recip_prod;
  logic [LW:0]             rem;
  logic [LW:0]             rem_fix;

  logic                    in_xfer;
  logic                    out_free;

  assign cfg_ready = !rst;
  assign in_ready  = (state == S_IDLE) && !rst;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign w_eff = (32'(cfg_width) > MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH) : cfg_width;
  assign h_eff = (32'(cfg_height) > MAX_HEIGHT) ? DIM_BITS'(MAX_HEIGHT) : cfg_height;
  assign cx    = w_eff[DIM_BITS-1:1];
  assign cy    = h_eff[DIM_BITS-1:1];

  // Destination point off the image: answer zero without mapping.
  assign off_dest = ({1'b0, col} >= w_eff) || ({1'b0, row} >= h_eff);

  assign dx = $signed({2'b00, col_r}) - $signed({2'b00, cx});
  assign dy = $signed({2'b00, row_r}) - $signed({2'b00, cy});

  // Truncate toward zero: shift the magnitude, then restore the sign.
  function automatic logic signed [CW-1:0] trunc_q(input logic signed [SW-1:0] v);
    logic [SW-1:0]  mag;
    logic [TQW-1:0] tq;
    mag = v[SW-1] ? SW'(-v) : SW'(v);
    tq  = mag[SW-1:FRAC_BITS];
    return v[SW-1] ? -$signed({2'b00, tq}) : $signed({2'b00, tq});
  endfunction

  assign sum_x = SW'(p_cos_dx) + SW'(p_sin_dy);
  assign sum_y = SW'(p_cos_dy) - SW'(p_sin_dx);
  assign tx    = trunc_q(sum_x);
  assign ty    = trunc_q(sum_y);

  assign map_inside = !sx[CW-1] && !sy[CW-1]
                   && ($unsigned(sx) < CW'(w_eff)) && ($unsigned(sy) < CW'(h_eff));

  // Linear address and its reduction modulo DEPTH.
  assign lin        = LW'(addr_row) * LW'(MAX_WIDTH) + LW'(addr_col);
  assign recip_prod = (LW+RW)'(lin_r) * (LW+RW)'(RECIP);
  assign rem        = (LW+1)'(lin_r) - (LW+1)'(q_r) * (LW+1)'(DEPTH);
  assign rem_fix    = (longint'(rem) >= DEPTH) ? rem - (LW+1)'(DEPTH) : rem;

  assign mem_we = (state == S_MEM) && (func_r == FUNC_LOAD);
  assign mem_re = (state == S_MEM) && (func_r == FUNC_QUERY);

  // Config register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= DIM_BITS'(256);
      cfg_height <= DIM_BITS'(256);
      cos_r      <= TRIG_BITS'(16384);
      sin_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_WIDTH:  cfg_width  <= cfg_data[DIM_BITS-1:0];
        REG_HEIGHT: cfg_height <= cfg_data[DIM_BITS-1:0];
        REG_COS:    cos_r      <= $signed(cfg_data);
        REG_SIN:    sin_r      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (out_ready)                out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (func == FUNC_LOAD) state <= S_LIN;
            else if (off_dest)     state <= S_DONE;
            else                   state <= S_MUL;
          end
        end
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_CHK;
        S_CHK:  state <= map_inside ? S_LIN : S_DONE;
        S_LIN:  state <= S_RCP;
        S_RCP:  state <= S_MOD;
        S_MOD:  state <= S_MEM;
        S_MEM:  state <= S_DONE;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r     <= func;
      col_r      <= col;
      row_r      <= row;
      pix_r      <= pixel_in[PIXEL_BITS-1:0];
      addr_col   <= DIM_BITS'(col);
      addr_row   <= DIM_BITS'(row);
      res_inside <= 1'b0;
    end
    if (state == S_MUL) begin
      p_cos_dx <= cos_r * dx;
      p_sin_dy <= sin_r * dy;
      p_sin_dx <= sin_r * dx;
      p_cos_dy <= cos_r * dy;
    end
    if (state == S_SUM) begin
      sx <= tx + $signed({{(CW-DIM_BITS+1){1'b0}}, cx});
      sy <= ty + $signed({{(CW-DIM_BITS+1){1'b0}}, cy});
    end
    if (state == S_CHK) begin
      res_inside <= map_inside;
      addr_col   <= sx[DIM_BITS-1:0];
      addr_row   <= sy[DIM_BITS-1:0];
    end
    if (state == S_LIN) lin_r  <= lin;
    if (state == S_RCP) q_r    <= recip_prod[LW+RW-1:LW];
    if (state == S_MOD) addr_r <= rem_fix[AW-1:0];
    if ((state == S_DONE) && out_free) begin
      pixel_out  <= res_inside ? PORT_PIX_BITS'(rd_data) : '0;
      inside_res <= res_inside;
    end
  end

  // Frame store: single port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) frame[addr_r] <= pix_r;
    if (mem_re) rd_data <= frame[addr_r];
  end

  `IRN_ASSERT_NEXT(a_busy_after_take, in_xfer, !in_ready, "input taken while busy")
  `IRN_ASSERT_IMP(a_outside_zero, out_valid && !inside_res, pixel_out == '0, "outside result not zero")
  `IRN_ASSERT_IMP(a_addr_in_frame, state == S_MEM, longint'(addr_r) < DEPTH, "frame address out of range")
  `IRN_ASSERT_NEXT(a_mem_to_done, state == S_MEM, state == S_DONE, "memory access not followed by result")
  `IRN_ASSERT_IMP(a_load_not_inside, (state == S_MEM) && (func_r == FUNC_LOAD), !res_inside, "load flagged inside")

endmodule
